### hdl/clh_pkg.sv
// ---------------------------------------------------------------------------
// clh_pkg: shared types and functions of the limb hash
// Queue entry format, limb classes and the unrolled 64-step CRC-64 fold.
// ---------------------------------------------------------------------------
package clh_pkg;

  localparam int unsigned LimbW         = 64;
  localparam int unsigned HashW         = 62;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [LimbW-1:0] CrcPoly = 64'hC96C5795D7870F42;

  typedef enum logic [1:0] {
    CLS_FOLD  = 2'd0,
    CLS_LAST  = 2'd1,
    CLS_EMPTY = 2'd2
  } limb_cls_e;

  typedef struct packed {
    logic [LimbW-1:0] limb;
    limb_cls_e        cls;
  } limb_entry_t;

  typedef logic [LimbW-1:0][LimbW-1:0] crc_mat_t;

  // bit-serial reference, only evaluated at elaboration
  function automatic logic [LimbW-1:0] crc_shift64(input logic [LimbW-1:0] x);
    logic [LimbW-1:0] c;
    c = x;
    for (int k = 0; k < LimbW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic crc_mat_t crc_build_mat();
    crc_mat_t         m;
    logic [LimbW-1:0] col;
    m = '0;
    for (int j = 0; j < LimbW; j++) begin
      col = crc_shift64(LimbW'(1) << j);
      for (int i = 0; i < LimbW; i++) begin
        m[i][j] = col[i];
      end
    end
    return m;
  endfunction

  localparam crc_mat_t CrcMat = crc_build_mat();

  // one xor tree per output bit
  function automatic logic [LimbW-1:0] crc_fold(input logic [LimbW-1:0] x);
    logic [LimbW-1:0] y;
    for (int i = 0; i < LimbW; i++) begin
      y[i] = ^(x & CrcMat[i]);
    end
    return y;
  endfunction

endpackage

### hdl/clh_front.sv
// ---------------------------------------------------------------------------
// clh_front: input stage of the limb hash
// Registers each limb transfer and tags it as fold, last or empty.
// ---------------------------------------------------------------------------
module clh_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [clh_pkg::LimbW-1:0]  limb_value_i,
  input  logic                       is_last_i,
  input  logic                       is_empty_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output clh_pkg::limb_entry_t       push_entry_o
);

  logic                 valid_q, valid_d;
  clh_pkg::limb_entry_t entry_q, entry_d;
  logic                 in_xfer;

  assign in_ready_o = !valid_q || push_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q && !push_ready_i;
    if (in_xfer) begin
      valid_d      = 1'b1;
      entry_d.limb = limb_value_i;
      if (is_empty_i) begin
        entry_d.cls = clh_pkg::CLS_EMPTY;
      end else if (is_last_i) begin
        entry_d.cls = clh_pkg::CLS_LAST;
      end else begin
        entry_d.cls = clh_pkg::CLS_FOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule

### hdl/clh_fifo.sv
// ---------------------------------------------------------------------------
// clh_fifo: queue between front and back
// Small circular buffer of classified limbs.
// ---------------------------------------------------------------------------
module clh_fifo #(
  parameter int unsigned Depth = clh_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  clh_pkg::limb_entry_t push_entry_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output clh_pkg::limb_entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clh_pkg::limb_entry_t mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### hdl/clh_back.sv
// ---------------------------------------------------------------------------
// clh_back: crc engine and masked-hash result register
// Folds one limb per cycle into the crc; a stalled output holds last/empty.
// ---------------------------------------------------------------------------
module clh_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  clh_pkg::limb_entry_t      pop_entry_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [clh_pkg::HashW-1:0] hash_value_o
);

  logic [clh_pkg::LimbW-1:0] crc_q, crc_d;
  logic [clh_pkg::LimbW-1:0] folded;
  logic [clh_pkg::HashW-1:0] hash_q, hash_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free, pop;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (pop_entry_i.cls == clh_pkg::CLS_FOLD) || out_free;
  assign pop         = pop_valid_i && pop_ready_o;
  assign folded      = clh_pkg::crc_fold(crc_q ^ pop_entry_i.limb);

  always_comb begin
    crc_d       = crc_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop) begin
      case (pop_entry_i.cls)
        clh_pkg::CLS_FOLD: begin
          crc_d = folded;
        end
        clh_pkg::CLS_LAST: begin
          crc_d       = '0;
          hash_d      = folded[clh_pkg::HashW-1:0];
          out_valid_d = 1'b1;
        end
        clh_pkg::CLS_EMPTY: begin
          crc_d       = '0;
          hash_d      = '0;
          out_valid_d = 1'b1;
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

### hdl/crc64_limb_hash.sv
// ---------------------------------------------------------------------------
// crc64_limb_hash: reflected crc-64 hash of a big integer in 64-bit limbs
// Front register, limb queue and combinational crc fold with result register.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | limb_value_i, is_last_i, is_empty_i
//  out     | output    | out_valid_o / out_ready_i  | hash_value_o
//
//  one limb transfer per cycle unless the queue backs up; the 64-step xor matrix is combinational
//  a last or empty transfer passes the front register and the queue; its hash lands in the result register
//  reset clears the crc, the queue and all valid flags; nothing to sweep
//  a stalled output blocks only last and empty limbs; plain limbs keep folding
// ---------------------------------------------------------------------------
module crc64_limb_hash #(
  parameter int unsigned QueueDepth = clh_pkg::QueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [clh_pkg::LimbW-1:0] limb_value_i,
  input  logic                      is_last_i,
  input  logic                      is_empty_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [clh_pkg::HashW-1:0] hash_value_o
);

  logic                 push_valid, push_ready;
  clh_pkg::limb_entry_t push_entry;
  logic                 pop_valid, pop_ready;
  clh_pkg::limb_entry_t pop_entry;

  clh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .limb_value_i (limb_value_i),
    .is_last_i    (is_last_i),
    .is_empty_i   (is_empty_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  clh_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  clh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_entry_i  (pop_entry),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  // full queue is never empty
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready |-> pop_valid)
    else $error("queue full but reports empty");

  // a plain limb never raises the output
  a_fold_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_entry.cls == clh_pkg::CLS_FOLD && !out_valid_o) |=> !out_valid_o)
    else $error("plain limb produced a result");

  // empty marker yields a zero hash
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && pop_entry.cls == clh_pkg::CLS_EMPTY)
      |=> (out_valid_o && hash_value_o == '0))
    else $error("empty marker gave nonzero hash");

  // a held front item with room in the queue moves on
  a_front_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && push_ready && !in_valid_i) |=> !push_valid || pop_valid)
    else $error("front transfer lost");

endmodule

### sim/tb_crc64_limb_hash.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_crc64_limb_hash: self-checking bench for the limb hash
// A queue-fed driver streams limb transfers. Each accepted limb but an empty
// marker goes through a bit-serial reflected crc-64 (ecma) so the expected hashes are known.
// A monitor compares each hash transfer against the oldest expected hash.
// Idling on both sides changes by phase. One long output stall fills the block.
// ---------------------------------------------------------------------------
module tb_crc64_limb_hash;

  localparam int unsigned LimbW         = clh_pkg::LimbW;
  localparam int unsigned HashW         = clh_pkg::HashW;
  localparam logic [LimbW-1:0] EcmaPoly = 64'hC96C5795D7870F42;
  localparam int unsigned NumItems      = 1375;
  localparam int unsigned Phase1Start   = 450;
  localparam int unsigned Phase2Start   = 900;
  localparam int unsigned HoldStart     = 950;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned TimeoutCycles = 300000;

  typedef struct {
    logic [LimbW-1:0] limb;
    logic             is_last;
    logic             is_empty;
  } limb_item_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic [LimbW-1:0] limb_value   = '0;
  logic             is_last      = 1'b0;
  logic             is_empty     = 1'b0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [HashW-1:0] hash_value;

  limb_item_t       pending_q[$];
  logic [HashW-1:0] expect_q[$];
  logic [LimbW-1:0] crc_acc = '0;
  limb_item_t       nxt_item;
  logic             snd_idle;
  logic [HashW-1:0] exp_hash;
  int unsigned      n_accepted = 0;
  int unsigned      n_checked  = 0;
  int unsigned      n_empty    = 0;
  int unsigned      n_err      = 0;
  int unsigned      hold_left  = 0;
  logic             hold_done  = 1'b0;
  int unsigned      phase;

  assign phase = (n_accepted < Phase1Start) ? 0 : (n_accepted < Phase2Start) ? 1 : 2;

  crc64_limb_hash u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .limb_value_i (limb_value),
    .is_last_i    (is_last),
    .is_empty_i   (is_empty),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hash_value_o (hash_value)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [LimbW-1:0] ecma_fold(input logic [LimbW-1:0] acc,
                                                 input logic [LimbW-1:0] limb);
    logic [LimbW-1:0] c;
    c = acc ^ limb;
    for (int k = 0; k < LimbW; k++) begin
      c = c[0] ? ((c >> 1) ^ EcmaPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [LimbW-1:0] rand_limb();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return LimbW'(1) << $urandom_range(LimbW - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_limb(input logic [LimbW-1:0] limb, input logic lst, input logic emp);
    limb_item_t it;
    it.limb     = limb;
    it.is_last  = lst;
    it.is_empty = emp;
    pending_q.push_back(it);
  endtask

  // predictor: runs on every accepted limb transfer
  task automatic hash_accept(input logic [LimbW-1:0] limb, input logic lst, input logic emp);
    if (emp) begin
      crc_acc = '0;
      expect_q.push_back('0);
      n_empty++;
    end else begin
      crc_acc = ecma_fold(crc_acc, limb);
      if (lst) begin
        expect_q.push_back(crc_acc[HashW-1:0]);
        crc_acc = '0;
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hash_accept(limb_value, is_last, is_empty);
        n_accepted <= n_accepted + 1;
      end
      snd_idle = (phase == 0) ? ($urandom_range(99) < 7) :
                 (phase == 1) ? ($urandom_range(99) < 77) : 1'b0;
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && !snd_idle) begin
          nxt_item   = pending_q.pop_front();
          limb_value <= nxt_item.limb;
          is_last    <= nxt_item.is_last;
          is_empty   <= nxt_item.is_empty;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          $error("unexpected hash transfer: hash_value %h", hash_value);
          n_err++;
        end else begin
          exp_hash = expect_q.pop_front();
          n_checked++;
          if (hash_value !== exp_hash) begin
            $error("hash_value mismatch: expected %h, actual %h", exp_hash, hash_value);
            n_err++;
          end
        end
      end
      if (!hold_done && n_accepted >= HoldStart) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (phase == 0) ? ($urandom_range(99) >= 77) :
                     (phase == 1) ? ($urandom_range(99) >= 7) : 1'b1;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned n;
    // directed: empty markers, extreme limbs, abandoned integer
    push_limb('0, 1'b0, 1'b1);
    push_limb('1, 1'b1, 1'b1);
    push_limb('0, 1'b1, 1'b0);
    push_limb('1, 1'b1, 1'b0);
    push_limb(64'd1, 1'b1, 1'b0);
    push_limb(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    push_limb(EcmaPoly, 1'b1, 1'b0);
    push_limb('1, 1'b0, 1'b0);
    push_limb('1, 1'b1, 1'b0);
    push_limb(64'h5555_5555_5555_5555, 1'b0, 1'b0);
    push_limb(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    push_limb({$urandom, $urandom}, 1'b1, 1'b0);
    push_limb(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
    push_limb('1, 1'b0, 1'b1);
    push_limb(64'hFEDC_BA98_7654_3210, 1'b1, 1'b0);
    push_limb('0, 1'b0, 1'b0);
    push_limb('0, 1'b0, 1'b0);
    push_limb(64'd1, 1'b1, 1'b0);
    push_limb({$urandom, $urandom}, 1'b1, 1'b1);
    // random: mostly whole integers, some markers and abandoned integers
    while (pending_q.size() < NumItems) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_limb({$urandom, $urandom}, 1'($urandom), 1'b1);
      end else if (r < 10) begin
        n = $urandom_range(3, 1);
        for (int k = 0; k < n; k++) push_limb(rand_limb(), 1'b0, 1'b0);
        push_limb({$urandom, $urandom}, 1'($urandom), 1'b1);
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
        for (int k = 1; k <= n; k++) push_limb(rand_limb(), k == n, 1'b0);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expect_q.size() != 0) begin
      $error("%0d expected hashes never arrived", expect_q.size());
      n_err++;
    end

    $display("run covered %0d limb transfers and %0d checked hashes, %0d of them empty markers",
             n_accepted, n_checked, n_empty);
    $display("idle phases on both sides plus a %0d-cycle output stall", HoldCycles);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
hdl/clh_pkg.sv
hdl/clh_front.sv
hdl/clh_fifo.sv
hdl/clh_back.sv
hdl/crc64_limb_hash.sv
sim/tb_crc64_limb_hash.sv
